// ===== sv/u128div_pkg.sv =====
// Package: item types and fixed widths for the 128-bit unsigned divider.
`timescale 1ns / 1ps
package u128div_pkg;

	localparam int unsigned HALF_W = 64;
	localparam int unsigned MAX_W  = 2 * HALF_W;

	// Operands of one division item
	typedef struct packed {
		logic [HALF_W-1:0] dividend_hi;
		logic [HALF_W-1:0] dividend_lo;
		logic [HALF_W-1:0] divisor_hi;
		logic [HALF_W-1:0] divisor_lo;
	} in_item_t;

	// Result of one division item
	typedef struct packed {
		logic [HALF_W-1:0] quotient_hi;
		logic [HALF_W-1:0] quotient_lo;
		logic [HALF_W-1:0] remainder_hi;
		logic [HALF_W-1:0] remainder_lo;
		logic              divide_by_zero;
	} out_item_t;

endpackage

// ===== sv/u128_restoring_divider_core.sv =====
// Top level: iterative radix-2 restoring divider, unsigned, up to 128 bits.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low. A nonzero divisor
// holds busy high while the loop runs; W is OPERAND_WIDTH held to 8..128 (128 by
// default). Each busy cycle gives one quotient bit through a single W+1 bit
// subtractor. The result shows on result with done high for one cycle right
// after the last iteration. A zero divisor skips the loop: done comes the cycle after
// start with divide_by_zero set, quotient zero and remainder equal to the
// dividend. The receiver cannot stall; it must take result whenever done is
// high. busy is low again in the done cycle, so a new item may start then.
// Operand bits above W are ignored and result bits above it are
// zero.
module u128_restoring_divider_core #(
	parameter int unsigned OPERAND_WIDTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  u128div_pkg::in_item_t  operands,
	output logic                   busy,
	output logic                   done,
	output u128div_pkg::out_item_t result
);
	import u128div_pkg::*;

	localparam int unsigned W =
		(OPERAND_WIDTH < 8) ? 8 : ((OPERAND_WIDTH > MAX_W) ? MAX_W : OPERAND_WIDTH);
	localparam int unsigned CNT_W = $clog2(W + 1);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	out_item_t         result_q;

	// Datapath: partial remainder, dividend shifting out / quotient shifting in
	logic [W-1:0]      rem_q;
	logic [W-1:0]      numq_q;
	logic [W-1:0]      den_q;

	logic [MAX_W-1:0]  dividend_full;
	logic [MAX_W-1:0]  divisor_full;
	logic [W-1:0]      dividend_m;
	logic [W-1:0]      divisor_m;
	logic              accept;
	logic [W:0]        shifted;
	logic [W:0]        diff;
	logic              take;
	logic [W-1:0]      rem_next;
	logic [W-1:0]      numq_next;
	logic [MAX_W-1:0]  quo_out;
	logic [MAX_W-1:0]  rem_out;
	logic [MAX_W-1:0]  zrem_out;

	// Operand masking to the working width
	assign dividend_full = {operands.dividend_hi, operands.dividend_lo};
	assign divisor_full  = {operands.divisor_hi, operands.divisor_lo};
	assign dividend_m    = dividend_full[W-1:0];
	assign divisor_m     = divisor_full[W-1:0];
	assign accept        = start && (state_q == ST_IDLE);

	// Shared step: shift in next dividend bit, trial subtract
	assign shifted   = {rem_q, numq_q[W-1]};
	assign diff      = shifted - {1'b0, den_q};
	assign take      = !diff[W];
	assign rem_next  = take ? diff[W-1:0] : shifted[W-1:0];
	assign numq_next = {numq_q[W-2:0], take};

	assign quo_out  = MAX_W'(numq_next);
	assign rem_out  = MAX_W'(rem_next);
	assign zrem_out = MAX_W'(dividend_m);

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= '0;
			numq_q <= dividend_m;
			den_q  <= divisor_m;
		end else if (state_q == ST_RUN) begin
			rem_q  <= rem_next;
			numq_q <= numq_next;
		end
	end

	// Sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (divisor_m == '0) begin
							done_q                  <= 1'b1;
							result_q.quotient_hi    <= '0;
							result_q.quotient_lo    <= '0;
							result_q.remainder_hi   <= zrem_out[MAX_W-1:HALF_W];
							result_q.remainder_lo   <= zrem_out[HALF_W-1:0];
							result_q.divide_by_zero <= 1'b1;
						end else begin
							state_q <= ST_RUN;
							cnt_q   <= CNT_W'(W);
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q                 <= ST_IDLE;
						done_q                  <= 1'b1;
						result_q.quotient_hi    <= quo_out[MAX_W-1:HALF_W];
						result_q.quotient_lo    <= quo_out[HALF_W-1:0];
						result_q.remainder_hi   <= rem_out[MAX_W-1:HALF_W];
						result_q.remainder_lo   <= rem_out[HALF_W-1:0];
						result_q.divide_by_zero <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q == ST_RUN);
	assign done   = done_q;
	assign result = result_q;

	// A result never shows while the loop still runs
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// An accepted item either starts the loop or answers at once
	a_accept_reacts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither started nor answered");

	// The iteration counter is live whenever the loop runs
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q != '0))
		else $error("loop running with zero count");

	// Divide by zero reports a zero quotient
	a_dbz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_by_zero) |->
			(result.quotient_hi == '0 && result.quotient_lo == '0))
		else $error("nonzero quotient on divide by zero");

endmodule

// ===== tb/sv/tb_u128_restoring_divider_core.sv =====
// Testbench: random and directed 128-bit divisions checked against a bit-serial model.
`timescale 1ns / 1ps
module tb_u128_restoring_divider_core;
	import u128div_pkg::*;

	localparam int unsigned OPERAND_W = 128;
	localparam int unsigned IDLE_PCT  = 18;
	localparam int unsigned MAX_GAP   = 300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  operands = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	// operand sets taken by the divider, oldest first
	in_item_t  divisions_in_flight[$];
	int unsigned mismatches = 0;

	u128_restoring_divider_core #(
		.OPERAND_WIDTH(OPERAND_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.operands(operands),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Bit-serial restoring division at the configured operand width
	function automatic out_item_t divide_u128(in_item_t op);
		logic [127:0] mask, num, den, quo;
		logic [128:0] rem;
		logic         take;
		out_item_t    r;
		int           w;
		int           i;
		w = (OPERAND_W < 8) ? 8 : ((OPERAND_W > 128) ? 128 : OPERAND_W);
		mask = '1;
		if (w < 128)
			mask = (128'd1 << w) - 128'd1;
		num = {op.dividend_hi, op.dividend_lo} & mask;
		den = {op.divisor_hi, op.divisor_lo} & mask;
		r = '0;
		if (den == '0) begin
			r.remainder_hi   = num[127:64];
			r.remainder_lo   = num[63:0];
			r.divide_by_zero = 1'b1;
			return r;
		end
		rem = '0;
		quo = '0;
		for (i = w - 1; i >= 0; i--) begin
			rem  = {rem[127:0], num[i]};
			take = (rem >= {1'b0, den});
			if (take)
				rem = rem - {1'b0, den};
			quo = {quo[126:0], take};
		end
		r.quotient_hi  = quo[127:64];
		r.quotient_lo  = quo[63:0];
		r.remainder_hi = rem[127:64];
		r.remainder_lo = rem[63:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Result check and acceptance tracking, sampled at each rising edge
	always @(posedge clk) begin
		in_item_t  op;
		out_item_t want;
		if (arst_n) begin
			if (done) begin
				if (divisions_in_flight.size() == 0) begin
					flag_mismatch("done with no division outstanding");
				end else begin
					op   = divisions_in_flight.pop_front();
					want = divide_u128(op);
					if (result.quotient_hi !== want.quotient_hi ||
					    result.quotient_lo !== want.quotient_lo ||
					    result.remainder_hi !== want.remainder_hi ||
					    result.remainder_lo !== want.remainder_lo ||
					    result.divide_by_zero !== want.divide_by_zero)
						flag_mismatch($sformatf(
							"%h%h / %h%h: q %h%h r %h%h z %b, want q %h%h r %h%h z %b",
							op.dividend_hi, op.dividend_lo, op.divisor_hi, op.divisor_lo,
							result.quotient_hi, result.quotient_lo,
							result.remainder_hi, result.remainder_lo, result.divide_by_zero,
							want.quotient_hi, want.quotient_lo,
							want.remainder_hi, want.remainder_lo, want.divide_by_zero));
				end
			end
			if (start && !busy)
				divisions_in_flight.push_back(operands);
		end
	end

	// Random value with at most len significant bits
	function automatic logic [127:0] rand_bits(int unsigned len);
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		if (len == 0)
			return '0;
		if (len < 128)
			v &= (128'd1 << len) - 128'd1;
		return v;
	endfunction

	function automatic in_item_t make_item(logic [127:0] num, logic [127:0] den);
		in_item_t it;
		it.dividend_hi = num[127:64];
		it.dividend_lo = num[63:0];
		it.divisor_hi  = den[127:64];
		it.divisor_lo  = den[63:0];
		return it;
	endfunction

	// Present one item, optionally after a random idle gap while the divider is free;
	// returns on the accepting edge
	task automatic send_division(input in_item_t op, input bit may_idle);
		if (may_idle && $urandom_range(99, 0) < IDLE_PCT) begin
			start    <= 1'b0;
			operands <= {$urandom, $urandom, $urandom, $urandom,
			             $urandom, $urandom, $urandom, $urandom};
			@(posedge clk);
			while (busy) @(posedge clk);
			repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
		end
		start    <= 1'b1;
		operands <= op;
		do @(posedge clk); while (busy);
	endtask

	task automatic test_directed_cases;
		logic [127:0] ones;
		ones = '1;
		send_division(make_item(ones, ones), 1'b0);
		send_division(make_item(ones, 128'd1), 1'b0);
		send_division(make_item('0, ones), 1'b0);
		send_division(make_item('0, '0), 1'b0);
		send_division(make_item(ones, '0), 1'b0);
		send_division(make_item(128'd1, 128'd1), 1'b0);
		send_division(make_item(ones, 128'd1 << 127), 1'b0);
		send_division(make_item(128'd1 << 127, 128'd3), 1'b0);
		send_division(make_item(128'd5, 128'd7), 1'b0);
		send_division(make_item(ones - 128'd1, ones), 1'b0);
		send_division(make_item({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 128'd2), 1'b0);
		send_division(make_item({64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
		                        {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}), 1'b0);
		send_division(make_item(ones, {64'h1, 64'h0}), 1'b0);
		send_division(make_item({64'h8000_0000_0000_0000, 64'h1}, 128'd10), 1'b0);
		send_division(make_item(128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210,
		                        128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210), 1'b0);
		send_division(make_item(128'd1, 128'd0), 1'b0);
		send_division(make_item(128'd1, ones), 1'b0);
		send_division(make_item(ones, 128'd3), 1'b0);
		send_division(make_item(128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA,
		                        128'h5555_5555_5555_5555_5555_5555_5555_5555), 1'b0);
		send_division(make_item(128'h5555_5555_5555_5555_5555_5555_5555_5555,
		                        128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA), 1'b0);
	endtask

	// Mix of operand shapes; shortcut cases and zero divisors kept in the blend
	task automatic random_division(input bit may_idle);
		logic [127:0] num, den;
		int unsigned  pick;
		pick = $urandom_range(99, 0);
		num  = rand_bits($urandom_range(128, 1));
		den  = rand_bits($urandom_range(128, 1));
		if (pick < 5)
			den = '0;
		else if (pick < 10)
			den = 128'd1;
		else if (pick < 15)
			den = num;
		else if (pick < 25)
			num = rand_bits($urandom_range(128, 0)) % ((den == '0) ? 128'd1 : den);
		else if (pick < 35) begin
			num = rand_bits(128);
			den = rand_bits(128);
		end
		send_division(make_item(num, den), may_idle);
	endtask

	task automatic test_zero_divisor;
		repeat (40)
			send_division(make_item(rand_bits($urandom_range(128, 0)), '0), 1'b1);
	endtask

	task automatic test_back_to_back;
		repeat (150) random_division(1'b0);
	endtask

	task automatic test_random_with_gaps;
		repeat (490) random_division(1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_cases();
		test_zero_divisor();
		test_back_to_back();
		test_random_with_gaps();
		start <= 1'b0;
		while (divisions_in_flight.size() != 0) @(posedge clk);
		repeat (OPERAND_W + 10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
